[rtl/mhcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mhcc_pkg;

    localparam int TABLE_INDEX_BITS_DEFAULT = 12;

    localparam int DATA_BITS     = 64;
    localparam int HALF_BITS     = 32;
    localparam int SHIFT_BITS    = 6;
    localparam int EPOCH_BITS    = 8;
    localparam int CFG_ADDR_BITS = 4;

    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 6'd52;

    // Register select: the register number is address bit 3 (8-byte spacing).
    localparam logic REG_MAGIC = 1'b0;
    localparam logic REG_SHIFT = 1'b1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_MUL0  = 8'b0000_0100,
        ST_MUL1  = 8'b0000_1000,
        ST_MUL2  = 8'b0001_0000,
        ST_MUL3  = 8'b0010_0000,
        ST_INDEX = 8'b0100_0000,
        ST_CHECK = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

[rtl/mhcc_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module mhcc_table #(
    parameter int ADDR_BITS = mhcc_pkg::TABLE_INDEX_BITS_DEFAULT,
    parameter int WORD_BITS = mhcc_pkg::DATA_BITS + mhcc_pkg::EPOCH_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WORD_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WORD_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WORD_BITS-1:0] table_mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/magic_hash_collision_check.sv]
`timescale 1ns / 1ps
`default_nettype none

// Checks one candidate multiplier against the occupancy/attack pairs of a trial. Each
// request is hashed as (blocker * multiplier) >> index_shift, taking the low
// TABLE_INDEX_BITS bits, and checked against a table of attack words held in one
// single-port-write, registered-read memory; one result per request reports the index,
// the sticky collision flag and the last-of-trial mark. Per request, the 64-bit product
// is built from three 32x32 partial products on one shared multiplier, then the table
// entry is read and filled if empty. Entries carry a trial tag, so starting a trial
// costs nothing; after reset, and again when a first-of-trial request arrives after 255
// trials have used up the tags, a clearing pass over all 2^TABLE_INDEX_BITS entries
// runs with s_ready low. Registers are magic_multiplier at address 0x0 and index_shift
// at 0x8, to be written by the user only while the block is idle; it is not enforced.
module magic_hash_collision_check #(
    parameter int TABLE_INDEX_BITS = mhcc_pkg::TABLE_INDEX_BITS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mhcc_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire logic [mhcc_pkg::DATA_BITS-1:0]      pwdata,
    output logic      [mhcc_pkg::DATA_BITS-1:0]      prdata,
    output logic                                     pready,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_first_of_trial,
    input  wire logic                                s_last_of_trial,
    input  wire logic [mhcc_pkg::DATA_BITS-1:0]      s_blocker_bits,
    input  wire logic [mhcc_pkg::DATA_BITS-1:0]      s_attack_bits,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [TABLE_INDEX_BITS-1:0]         m_table_index,
    output logic                                     m_collision_seen,
    output logic                                     m_trial_done
);

    localparam int DB = mhcc_pkg::DATA_BITS;
    localparam int HB = mhcc_pkg::HALF_BITS;
    localparam int EB = mhcc_pkg::EPOCH_BITS;
    localparam int WORD_BITS = DB + EB;

    mhcc_pkg::state_t state_reg, state_next;

    logic [DB-1:0]                    magic_reg, magic_next;
    logic [mhcc_pkg::SHIFT_BITS-1:0]  shift_reg, shift_next;

    logic                             last_reg;
    logic [DB-1:0]                    blk_reg;
    logic [DB-1:0]                    atk_reg;

    logic [EB-1:0]                    epoch_reg, epoch_next;
    logic                             flag_reg, flag_next;
    logic [TABLE_INDEX_BITS-1:0]      clr_cnt_reg, clr_cnt_next;

    logic [HB-1:0]                    op_a;
    logic [HB-1:0]                    op_b;
    logic [DB-1:0]                    mul_reg;
    logic [DB-1:0]                    product_reg, product_next;
    logic [DB-1:0]                    shifted;
    logic [TABLE_INDEX_BITS-1:0]      slot_comb;
    logic [TABLE_INDEX_BITS-1:0]      slot_reg;

    logic                             m_valid_reg, m_valid_next;
    logic [TABLE_INDEX_BITS-1:0]      m_index_reg;
    logic                             m_coll_reg;
    logic                             m_done_reg;

    logic                             wr_en;
    logic [TABLE_INDEX_BITS-1:0]      wr_addr;
    logic [WORD_BITS-1:0]             wr_data;
    logic                             rd_en;
    logic [WORD_BITS-1:0]             rd_data;

    logic                             cfg_write;
    logic                             epoch_max;
    logic                             s_fire;
    logic                             out_free;
    logic                             check_fire;
    logic [DB-1:0]                    entry_data;
    logic                             entry_live;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[3] == mhcc_pkg::REG_SHIFT)
                     ? {{(DB - mhcc_pkg::SHIFT_BITS){1'b0}}, shift_reg}
                     : magic_reg;

    always_comb begin
        magic_next = magic_reg;
        shift_next = shift_reg;
        if (cfg_write) begin
            if (paddr[3] == mhcc_pkg::REG_MAGIC) begin
                magic_next = pwdata;
            end else begin
                shift_next = pwdata[mhcc_pkg::SHIFT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg <= '0;
            shift_reg <= mhcc_pkg::SHIFT_RESET;
        end else begin
            magic_reg <= magic_next;
            shift_reg <= shift_next;
        end
    end

    // A new trial needs a fresh tag; when none is left the table is swept first.
    assign epoch_max = &epoch_reg;
    assign s_ready   = (state_reg == mhcc_pkg::ST_IDLE) && !(s_first_of_trial && epoch_max);
    assign s_fire    = s_valid && s_ready;

    assign out_free   = !m_valid_reg || m_ready;
    assign check_fire = (state_reg == mhcc_pkg::ST_CHECK) && out_free;

    // Shared 32x32 multiplier: low*low, low*high, high*low.
    always_comb begin
        case (state_reg)
            mhcc_pkg::ST_MUL1: begin
                op_a = blk_reg[HB-1:0];
                op_b = magic_reg[DB-1:HB];
            end
            mhcc_pkg::ST_MUL2: begin
                op_a = blk_reg[DB-1:HB];
                op_b = magic_reg[HB-1:0];
            end
            default: begin
                op_a = blk_reg[HB-1:0];
                op_b = magic_reg[HB-1:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_reg <= DB'(op_a) * DB'(op_b);
    end

    // Only the low halves of the cross products reach the low 64 bits.
    always_comb begin
        product_next = product_reg;
        case (state_reg)
            mhcc_pkg::ST_MUL1: begin
                product_next = mul_reg;
            end
            mhcc_pkg::ST_MUL2, mhcc_pkg::ST_MUL3: begin
                product_next = {product_reg[DB-1:HB] + mul_reg[HB-1:0], product_reg[HB-1:0]};
            end
            default: begin
                product_next = product_reg;
            end
        endcase
    end

    assign shifted   = product_reg >> shift_reg;
    assign slot_comb = shifted[TABLE_INDEX_BITS-1:0];

    // An entry written under an older trial tag reads as empty.
    assign entry_live = (rd_data[DB +: EB] == epoch_reg);
    assign entry_data = entry_live ? rd_data[DB-1:0] : '0;

    always_comb begin
        state_next   = state_reg;
        epoch_next   = epoch_reg;
        flag_next    = flag_reg;
        clr_cnt_next = clr_cnt_reg;
        wr_en        = 1'b0;
        wr_addr      = slot_reg;
        wr_data      = {epoch_reg, atk_reg};
        rd_en        = 1'b0;
        case (state_reg)
            mhcc_pkg::ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    epoch_next = '0;
                    state_next = mhcc_pkg::ST_IDLE;
                end
            end
            mhcc_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_first_of_trial) begin
                        epoch_next = epoch_reg + 1'b1;
                        flag_next  = 1'b0;
                    end
                    state_next = mhcc_pkg::ST_MUL0;
                end else if (s_valid && s_first_of_trial && epoch_max) begin
                    state_next = mhcc_pkg::ST_CLEAR;
                end
            end
            mhcc_pkg::ST_MUL0: begin
                state_next = mhcc_pkg::ST_MUL1;
            end
            mhcc_pkg::ST_MUL1: begin
                state_next = mhcc_pkg::ST_MUL2;
            end
            mhcc_pkg::ST_MUL2: begin
                state_next = mhcc_pkg::ST_MUL3;
            end
            mhcc_pkg::ST_MUL3: begin
                state_next = mhcc_pkg::ST_INDEX;
            end
            mhcc_pkg::ST_INDEX: begin
                rd_en      = 1'b1;
                state_next = mhcc_pkg::ST_CHECK;
            end
            mhcc_pkg::ST_CHECK: begin
                if (out_free) begin
                    if (!flag_reg) begin
                        if (entry_data == '0) begin
                            wr_en = 1'b1;
                        end else if (entry_data != atk_reg) begin
                            flag_next = 1'b1;
                        end
                    end
                    state_next = mhcc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mhcc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (check_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mhcc_pkg::ST_CLEAR;
            epoch_reg   <= '0;
            flag_reg    <= 1'b0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            epoch_reg   <= epoch_next;
            flag_reg    <= flag_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        product_reg <= product_next;
        if (s_fire) begin
            last_reg  <= s_last_of_trial;
            blk_reg   <= s_blocker_bits;
            atk_reg   <= s_attack_bits;
        end
        if (state_reg == mhcc_pkg::ST_INDEX) begin
            slot_reg <= slot_comb;
        end
        if (check_fire) begin
            m_index_reg <= slot_reg;
            m_coll_reg  <= flag_next;
            m_done_reg  <= last_reg;
        end
    end

    mhcc_table #(
        .ADDR_BITS (TABLE_INDEX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (slot_comb),
        .rd_data (rd_data)
    );

    assign m_valid          = m_valid_reg;
    assign m_table_index    = m_index_reg;
    assign m_collision_seen = m_coll_reg;
    assign m_trial_done     = m_done_reg;

endmodule

`default_nettype wire

[rtl/mhcc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mhcc_checker #(
    parameter int TABLE_INDEX_BITS = mhcc_pkg::TABLE_INDEX_BITS_DEFAULT
) (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [TABLE_INDEX_BITS-1:0] m_table_index,
    input wire logic                        m_collision_seen,
    input wire logic                        m_trial_done
);

    // Requests taken in whose results have not yet been delivered.
    logic [2:0] pending_reg, pending_next;

    assign pending_next = pending_reg + 3'(s_valid && s_ready) - 3'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // Reset starts the clearing sweep, so nothing is taken or shown right after it.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("requests or results active right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_table_index)
                                && $stable(m_collision_seen) && $stable(m_trial_done))
        else $error("stalled result changed");

    // One request in the pipeline and one waiting at the output at most.
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd2)
        else $error("more requests in flight than the block can hold");

    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("result shown with no request outstanding");

endmodule

bind magic_hash_collision_check mhcc_checker #(
    .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
) u_mhcc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_table_index    (m_table_index),
    .m_collision_seen (m_collision_seen),
    .m_trial_done     (m_trial_done)
);

`default_nettype wire
